FILE: design/serial_frame_field_parser_assert.svh
// Assertion macros used by the serial frame field parser top level.
`ifndef SERIAL_FRAME_FIELD_PARSER_ASSERT_SVH
`define SERIAL_FRAME_FIELD_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SFFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SFFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/sffp_pkg.sv
// Types and constants of the serial frame field parser.
`default_nettype none

package sffp_pkg;

    localparam int WIN_LEN = 8;
    localparam int CNT_W   = 6;

    localparam logic [7:0] HDR_BYTE   = 8'h05;
    localparam logic [7:0] TYPE_CODE  = 8'h25;
    localparam logic [7:0] TYPE_M1    = 8'h5a;
    localparam logic [7:0] TYPE_M4    = 8'h5d;
    localparam logic [7:0] TYPE_BASE  = 8'h59;
    localparam logic [7:0] ASCII_CR   = 8'h0d;
    localparam logic [7:0] ASCII_LF   = 8'h0a;
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    localparam logic [CNT_W-1:0] LEN_SHORT = CNT_W'(6);
    localparam logic [CNT_W-1:0] LEN_MID   = CNT_W'(7);
    localparam logic [CNT_W-1:0] LEN_LONG  = CNT_W'(8);

    localparam logic [2:0] KIND_CODE = 3'd0;

    typedef logic [WIN_LEN-1:0][7:0] window_t;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0] record_kind;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [7:0] byte_c;
        logic       done_flag;
    } out_item_t;

    typedef struct packed {
        window_t          bytes;
        logic [CNT_W-1:0] count;
        logic             fresh;
    } win_view_t;

endpackage

`default_nettype wire

FILE: design/sffp_window.sv
// Byte window and frame byte counter of the serial frame field parser.
`default_nettype none

module sffp_window #(
    parameter int MAX_FRAME_BYTES = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire sffp_pkg::in_item_t item,
    output sffp_pkg::win_view_t    view
);
    import sffp_pkg::*;

    localparam logic [CNT_W-1:0] MaxCount = CNT_W'(MAX_FRAME_BYTES);

    window_t          win_reg;
    window_t          win_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             room;
    window_t          shifted;

    assign room    = count_reg < MaxCount;
    assign shifted = {win_reg[WIN_LEN-2:0], item.rx_byte};

    assign view.bytes = shifted;
    assign view.count = count_reg + CNT_W'(1);
    assign view.fresh = !item.action && room;

    always_comb
    begin
        win_next   = win_reg;
        count_next = count_reg;
        if (accept)
        begin
            priority if (item.action)
            begin
                win_next   = '0;
                count_next = '0;
            end
            else if (room)
            begin
                win_next   = shifted;
                count_next = view.count;
            end
            else
            begin
                win_next   = win_reg;
                count_next = count_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            win_reg   <= win_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/sffp_decode.sv
// Record matcher and field extraction of the serial frame field parser.
`default_nettype none

module sffp_decode (
    input  wire sffp_pkg::win_view_t view,
    output logic                     rec_valid,
    output sffp_pkg::out_item_t      rec
);
    import sffp_pkg::*;

    window_t     w;
    logic        hdr6;
    logic        hdr7;
    logic        hdr8;
    logic        crlf_end;
    logic        crlf_mid;
    logic        crlf_far;
    logic [7:0]  kind6;
    logic [7:0]  kind7;
    logic [7:0]  kind8;
    logic [7:0]  one_digit;
    logic [7:0]  two_digit;
    logic [15:0] d4;
    logic [15:0] d3;
    logic [15:0] d2;
    logic [15:0] three_digit;

    function automatic logic is_short(input logic [7:0] t);
        return (t >= TYPE_M1) && (t < TYPE_M4);
    endfunction

    assign w = view.bytes;

    assign hdr6 = (view.count >= LEN_SHORT) && (w[5] == HDR_BYTE) && (w[4] == HDR_BYTE);
    assign hdr7 = (view.count >= LEN_MID) && (w[6] == HDR_BYTE) && (w[5] == HDR_BYTE);
    assign hdr8 = (view.count >= LEN_LONG) && (w[7] == HDR_BYTE) && (w[6] == HDR_BYTE);

    assign crlf_end = (w[1] == ASCII_CR) && (w[0] == ASCII_LF);
    assign crlf_mid = (w[2] == ASCII_CR) && (w[1] == ASCII_LF);
    assign crlf_far = (w[3] == ASCII_CR) && (w[2] == ASCII_LF);

    assign kind6 = w[3] - TYPE_BASE;
    assign kind7 = w[4] - TYPE_BASE;
    assign kind8 = w[5] - TYPE_BASE;

    assign one_digit = w[2] - ASCII_ZERO;
    assign two_digit = 8'((w[3] - ASCII_ZERO) * 8'd10) + (w[2] - ASCII_ZERO);

    assign d4 = {8'h00, w[4]} - {8'h00, ASCII_ZERO};
    assign d3 = {8'h00, w[3]} - {8'h00, ASCII_ZERO};
    assign d2 = {8'h00, w[2]} - {8'h00, ASCII_ZERO};
    assign three_digit = 16'(d4 * 16'd100) + 16'(d3 * 16'd10) + d2;

    always_comb
    begin
        rec_valid = 1'b0;
        rec       = '0;
        priority if (!view.fresh)
        begin
            rec_valid = 1'b0;
        end
        else if (hdr6)
        begin
            priority if (w[3] == TYPE_CODE)
            begin
                rec_valid       = 1'b1;
                rec.record_kind = KIND_CODE;
                rec.byte_a      = w[2];
                rec.byte_b      = w[1];
                rec.byte_c      = w[0];
                rec.done_flag   = 1'b1;
            end
            else if (is_short(w[3]) && crlf_end)
            begin
                rec_valid       = 1'b1;
                rec.record_kind = kind6[2:0];
                rec.byte_b      = one_digit;
            end
            else
            begin
                rec_valid = 1'b0;
            end
        end
        else if (hdr7)
        begin
            if (is_short(w[4]) && !crlf_mid && crlf_end)
            begin
                rec_valid       = 1'b1;
                rec.record_kind = kind7[2:0];
                rec.byte_b      = two_digit;
            end
        end
        else if (hdr8)
        begin
            if (((w[5] == TYPE_M4) && crlf_end) ||
                (is_short(w[5]) && !crlf_far && !crlf_mid && crlf_end))
            begin
                rec_valid       = 1'b1;
                rec.record_kind = kind8[2:0];
                rec.byte_a      = three_digit[15:8];
                rec.byte_b      = three_digit[7:0];
                rec.done_flag   = (w[5] == TYPE_M4);
            end
        end
        else
        begin
            rec_valid = 1'b0;
        end
    end

endmodule

`default_nettype wire

FILE: design/serial_frame_field_parser.sv
// Top level of the serial frame field parser.
//
// Input channel (in_valid, in_ready, in_data): one request per received byte
// or per line-idle event. An idle request clears the frame window and count.
// Bytes beyond MAX_FRAME_BYTES in one frame are dropped.
// Output channel (out_valid, out_ready, out_data): one record per request
// that completes a code or measurement record, none otherwise.
// A record appears on out_valid in the cycle after the request that
// completes it is accepted.
// One request per cycle unless a held record is stalled; the window shift,
// header match and decimal sum are combinational before the output register.
// When the receiver stalls, the output register holds its record and
// in_ready stays low until the record is taken; in the cycle it is taken a
// new request can be accepted.
// Reset clears the window, the frame count and the output valid flag.
`default_nettype none

module serial_frame_field_parser #(
    parameter int MAX_FRAME_BYTES = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire sffp_pkg::in_item_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output sffp_pkg::out_item_t     out_data
);
    import sffp_pkg::*;

    `include "serial_frame_field_parser_assert.svh"

    win_view_t view;
    logic      in_fire;
    logic      rec_valid;
    out_item_t rec;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_data_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    sffp_window #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .accept(in_fire),
        .item  (in_data),
        .view  (view)
    );

    sffp_decode u_decode (
        .view     (view),
        .rec_valid(rec_valid),
        .rec      (rec)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (in_fire)
            out_valid_next = rec_valid;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && rec_valid)
            out_data_reg <= rec;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `SFFP_ASSERT_NEXT(a_idle_no_record, clk, rst_n, in_fire && in_data.action, !out_valid, "idle request produced a record")
    `SFFP_ASSERT_NOW(a_record_needs_byte, clk, rst_n, rec_valid, view.fresh && (view.count >= LEN_SHORT), "record without a fresh frame byte")
    `SFFP_ASSERT_NEXT(a_record_loaded, clk, rst_n, in_fire && rec_valid, out_valid && (out_data == $past(rec)), "record not loaded into output register")

endmodule

`default_nettype wire

FILE: verif/serial_frame_field_parser_tb.sv
// Self-checking testbench for the serial frame field parser.
`default_nettype none

module serial_frame_field_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sffp_pkg::*;

    localparam int FRAME_LIMIT    = 32;
    localparam int PHASE_REQS     = 260;
    localparam int HOLD_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT = 2000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    in_item_t   pending_reqs[$];
    out_item_t  expected_records[$];
    logic [7:0] rec_bytes[$];

    logic [7:0]       frame_win [WIN_LEN];
    logic [CNT_W-1:0] frame_cnt = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_armed = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int phase_reqs = 0;

    int mismatches = 0;
    int records_checked = 0;
    int reqs_sent = 0;
    int idle_events = 0;
    int dropped_bytes = 0;

    serial_frame_field_parser #(
        .MAX_FRAME_BYTES(FRAME_LIMIT)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit is_crlf(input logic [7:0] first, input logic [7:0] second);
        return first == ASCII_CR && second == ASCII_LF;
    endfunction

    function automatic bit is_meas_short(input logic [7:0] t);
        return t >= TYPE_M1 && t < TYPE_M4;
    endfunction

    function automatic logic [31:0] digit_value(input logic [7:0] b);
        return {24'h0, b} - {24'h0, ASCII_ZERO};
    endfunction

    function automatic bit parse_request(input in_item_t req, output out_item_t rec);
        logic [31:0] val;
        logic [7:0]  kind;
        bit          ok;
        rec = '0;
        if (req.action)
        begin
            foreach (frame_win[i])
                frame_win[i] = 8'h00;
            frame_cnt = '0;
            return 1'b0;
        end
        if (frame_cnt >= FRAME_LIMIT)
        begin
            dropped_bytes++;
            return 1'b0;
        end
        for (int i = WIN_LEN - 1; i > 0; i--)
            frame_win[i] = frame_win[i - 1];
        frame_win[0] = req.rx_byte;
        frame_cnt = frame_cnt + 1'b1;

        if (frame_cnt >= LEN_SHORT && frame_win[5] == HDR_BYTE && frame_win[4] == HDR_BYTE)
        begin
            if (frame_win[3] == TYPE_CODE)
            begin
                rec.record_kind = KIND_CODE;
                rec.byte_a = frame_win[2];
                rec.byte_b = frame_win[1];
                rec.byte_c = frame_win[0];
                rec.done_flag = 1'b1;
                return 1'b1;
            end
            if (is_meas_short(frame_win[3]) && is_crlf(frame_win[1], frame_win[0]))
            begin
                kind = frame_win[3] - TYPE_BASE;
                val = digit_value(frame_win[2]);
                rec.record_kind = kind[2:0];
                rec.byte_b = val[7:0];
                return 1'b1;
            end
            return 1'b0;
        end

        if (frame_cnt >= LEN_MID && frame_win[6] == HDR_BYTE && frame_win[5] == HDR_BYTE)
        begin
            if (is_meas_short(frame_win[4]) && !is_crlf(frame_win[2], frame_win[1])
                && is_crlf(frame_win[1], frame_win[0]))
            begin
                kind = frame_win[4] - TYPE_BASE;
                val = digit_value(frame_win[3]) * 32'd10 + digit_value(frame_win[2]);
                rec.record_kind = kind[2:0];
                rec.byte_b = val[7:0];
                return 1'b1;
            end
            return 1'b0;
        end

        if (frame_cnt >= LEN_LONG && frame_win[7] == HDR_BYTE && frame_win[6] == HDR_BYTE)
        begin
            if (frame_win[5] == TYPE_M4)
                ok = is_crlf(frame_win[1], frame_win[0]);
            else
                ok = is_meas_short(frame_win[5]) && !is_crlf(frame_win[3], frame_win[2])
                     && !is_crlf(frame_win[2], frame_win[1]) && is_crlf(frame_win[1], frame_win[0]);
            if (ok)
            begin
                kind = frame_win[5] - TYPE_BASE;
                val = digit_value(frame_win[4]) * 32'd100 + digit_value(frame_win[3]) * 32'd10
                      + digit_value(frame_win[2]);
                rec.record_kind = kind[2:0];
                rec.byte_a = val[15:8];
                rec.byte_b = val[7:0];
                rec.done_flag = (frame_win[5] == TYPE_M4);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Request stimulus
    task automatic push_req(input logic act, input logic [7:0] b);
        in_item_t req;
        req.action = act;
        req.rx_byte = b;
        pending_reqs.push_back(req);
        phase_reqs++;
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_req(1'b0, b);
    endtask

    task automatic push_code(input logic [7:0] c1, input logic [7:0] c2, input logic [7:0] c3);
        push_byte(HDR_BYTE);
        push_byte(HDR_BYTE);
        push_byte(TYPE_CODE);
        push_byte(c1);
        push_byte(c2);
        push_byte(c3);
    endtask

    task automatic push_meas(input logic [7:0] t, input int digits, input logic [7:0] d0,
                             input logic [7:0] d1, input logic [7:0] d2);
        push_byte(HDR_BYTE);
        push_byte(HDR_BYTE);
        push_byte(t);
        push_byte(d0);
        if (digits >= 2)
            push_byte(d1);
        if (digits == 3)
            push_byte(d2);
        push_byte(ASCII_CR);
        push_byte(ASCII_LF);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return HDR_BYTE;
            1: return ASCII_CR;
            2: return ASCII_LF;
            3, 4: return 8'(ASCII_ZERO + $urandom_range(9));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic make_record(input bit clean);
        logic [7:0] t;
        int         digits;
        rec_bytes.delete();
        rec_bytes.push_back(HDR_BYTE);
        rec_bytes.push_back(HDR_BYTE);
        if ($urandom_range(3) == 0)
        begin
            rec_bytes.push_back(TYPE_CODE);
            repeat (3)
                rec_bytes.push_back(clean ? 8'($urandom_range(255)) : pick_byte());
        end
        else
        begin
            if ($urandom_range(9) == 0)
                t = 8'($urandom_range(255));
            else
                t = 8'(TYPE_M1 + $urandom_range(3));
            if (t == TYPE_M4 && $urandom_range(3) != 0)
                digits = 3;
            else
                digits = $urandom_range(3, 1);
            rec_bytes.push_back(t);
            repeat (digits)
                rec_bytes.push_back(clean ? 8'(ASCII_ZERO + $urandom_range(9)) : pick_byte());
            rec_bytes.push_back(ASCII_CR);
            rec_bytes.push_back(ASCII_LF);
        end
    endtask

    task automatic add_segment();
        int pick;
        int cut;
        int spot;
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            make_record($urandom_range(7) != 0);
            foreach (rec_bytes[i])
                push_byte(rec_bytes[i]);
        end
        else if (pick < 60)
        begin
            make_record(1'($urandom_range(1)));
            if ($urandom_range(1))
            begin
                cut = $urandom_range(rec_bytes.size() - 1, 1);
                for (int i = 0; i < cut; i++)
                    push_byte(rec_bytes[i]);
            end
            else
            begin
                spot = $urandom_range(rec_bytes.size() - 1);
                rec_bytes[spot] = pick_byte();
                foreach (rec_bytes[i])
                    push_byte(rec_bytes[i]);
            end
        end
        else if (pick < 75)
            repeat ($urandom_range(6, 1))
                push_byte(pick_byte());
        else if (pick < 93)
            push_req(1'b1, 8'($urandom_range(255)));
        else
            repeat ($urandom_range(40, 20))
                push_byte(pick_byte());
    endtask

    // Driver: offer requests, predict records on acceptance
    always @(posedge clk or negedge rst_n)
    begin : drive_reqs
        logic      nxt_valid;
        in_item_t  nxt_data;
        out_item_t rec;
        bit        hit;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            foreach (frame_win[i])
                frame_win[i] = 8'h00;
            frame_cnt = '0;
        end
        else
        begin
            nxt_valid = in_valid;
            nxt_data = in_data;
            if (in_valid && in_ready)
            begin
                reqs_sent++;
                if (in_data.action)
                    idle_events++;
                hit = parse_request(in_data, rec);
                if (hit)
                    expected_records.push_back(rec);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt_data = pending_reqs.pop_front();
                nxt_valid = 1'b1;
            end
            in_valid <= nxt_valid;
            in_data <= nxt_data;
        end
    end

    // Receiver: random stalls plus one long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left = 0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (hold_armed && !hold_taken && out_valid)
        begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: compare each record with the oldest prediction
    always @(posedge clk)
    begin : check_records
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_records.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected record kind %0d a %02h b %02h c %02h done %0b", $time,
                         out_data.record_kind, out_data.byte_a, out_data.byte_b,
                         out_data.byte_c, out_data.done_flag);
            end
            else
            begin
                want = expected_records.pop_front();
                records_checked++;
                if (out_data.record_kind !== want.record_kind || out_data.byte_a !== want.byte_a
                    || out_data.byte_b !== want.byte_b || out_data.byte_c !== want.byte_c
                    || out_data.done_flag !== want.done_flag)
                begin
                    mismatches++;
                    $display("%0t: record mismatch: expected kind %0d a %02h b %02h c %02h done %0b",
                             $time, want.record_kind, want.byte_a, want.byte_b, want.byte_c,
                             want.done_flag);
                    $display("%0t:                  actual   kind %0d a %02h b %02h c %02h done %0b",
                             $time, out_data.record_kind, out_data.byte_a, out_data.byte_b,
                             out_data.byte_c, out_data.done_flag);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
                    $display("serial_frame_field_parser verification failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin : stimulus
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (int phase = 0; phase < 4; phase++)
        begin
            while (pending_reqs.size() != 0)
                @(negedge clk);
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            phase_reqs = 0;
            if (phase == 0)
            begin
                hold_armed = 1'b1;
                push_req(1'b1, 8'hff);
                push_code(8'hff, 8'h00, 8'h80);
                push_req(1'b1, 8'h00);
                push_meas(TYPE_M4, 3, 8'h39, 8'h39, 8'h39);
                push_meas(TYPE_M1, 1, 8'hff, 8'h00, 8'h00);
                push_meas(8'h5b, 2, 8'h34, 8'h32, 8'h00);
            end
            while (phase_reqs < PHASE_REQS)
                add_segment();
        end
        while (pending_reqs.size() != 0 || in_valid || expected_records.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        $display("Covered %0d requests (%0d line-idle, %0d bytes past the frame limit) and",
                 reqs_sent, idle_events, dropped_bytes);
        $display("checked %0d records over four idle/stall mixes with one long receiver hold.",
                 records_checked);
        if (mismatches == 0)
            $display("serial_frame_field_parser verification clean");
        else
            $display("serial_frame_field_parser verification failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+design
design/sffp_pkg.sv
design/sffp_window.sv
design/sffp_decode.sv
design/serial_frame_field_parser.sv
verif/serial_frame_field_parser_tb.sv
